### sv/multimode_state_variable_filter_top_assert.svh
// assertion helpers shared by the filter rtl
`ifndef MULTIMODE_STATE_VARIABLE_FILTER_TOP_ASSERT_SVH
`define MULTIMODE_STATE_VARIABLE_FILTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define MSVF_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define MSVF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/msvf_pkg.sv
package msvf_pkg;

    localparam int STATE_BITS = 32;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = 60;
    localparam int DIV_W      = 58;
    localparam int DEN_W      = 34;
    localparam int CFG_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int COEF_W     = 23;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [GAIN_W-1:0] LP_GAIN_RST = 24'sd65536;
    localparam logic [COEF_W-1:0]        DAMPING_RST = 23'd46341;

    typedef logic signed [PROD_W-1:0]     t_wide;
    typedef logic signed [STATE_BITS-1:0] t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HP_GAIN = 3'd0,
        REG_BP_GAIN = 3'd1,
        REG_LP_GAIN = 3'd2,
        REG_DAMPING = 3'd3,
        REG_CUTOFF  = 3'd4
    } t_reg_idx;

    function automatic t_state sat_state(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (STATE_BITS - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (v > hi) begin
            return t_state'(hi);
        end else if (v < lo) begin
            return t_state'(lo);
        end
        return t_state'(v);
    endfunction

endpackage

### sv/msvf_mul.sv
module msvf_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [msvf_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [msvf_pkg::MUL_B_W-1:0]  i_b,
    output logic                                 o_done,
    output msvf_pkg::t_wide                      o_prod
);
    import msvf_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic signed [MUL_A_W-1:0] r_a;
    logic signed [MUL_A_W:0]   r_hi;
    logic [MUL_B_W-1:0]        r_lo;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic                      w_last;
    logic signed [MUL_A_W+1:0] w_add;
    logic signed [MUL_A_W+1:0] w_sum;
    logic [MUL_A_W+MUL_B_W:0]  w_full;

    // one multiplier bit per cycle, lsb first; the sign bit weighs negative
    assign w_last = (r_cnt == CNT_W'(MUL_B_W - 1));

    always_comb begin
        w_add = '0;
        if (r_lo[0]) begin
            w_add = w_last ? -(MUL_A_W+2)'(r_a) : (MUL_A_W+2)'(r_a);
        end
        w_sum = (MUL_A_W+2)'(r_hi) + w_add;
    end

    assign w_full = {r_hi, r_lo};
    assign o_prod = t_wide'(w_full[PROD_W-1:0]);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[MUL_A_W+1:1];
                r_lo  <= {w_sum[0], r_lo[MUL_B_W-1:1]};
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### sv/msvf_div.sv
module msvf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  msvf_pkg::t_wide                 i_num,
    input  logic [msvf_pkg::DEN_W-1:0]      i_den,
    output logic                            o_done,
    output msvf_pkg::t_wide                 o_quot
);
    import msvf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    t_wide            w_mag;
    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    t_wide            w_q;

    assign w_mag    = i_num[PROD_W-1] ? -i_num : i_num;
    assign w_rem_sh = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_q      = $signed({{(PROD_W-DIV_W){1'b0}}, r_dvd});
    assign o_quot   = r_neg ? -w_q : w_q;
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // magnitude plus half the divisor gives round to nearest
                r_dvd  <= DIV_W'(w_mag) + DIV_W'(i_den >> 1);
                r_den  <= i_den;
                r_rem  <= '0;
                r_neg  <= i_num[PROD_W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_dvd <= {r_dvd[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### sv/multimode_state_variable_filter_top.sv
// channel   direction  signals
// input     in         i_in_valid, o_in_stall, i_sample_in
// output    out        o_out_valid, i_out_stall, o_sample_out
// config    in         i_cfg_we, i_cfg_index, i_cfg_data
//
// a word's result is posted after seven serial multiplies (start, 26 bit steps, done), a
// serial divide (start, 58 bit steps, done) and the output step, which can wait on
// i_out_stall; the next word is taken only once the machine is back in idle.
// the bit-serial divider for the bandpass term is the longest single step.
// i_rst_n is synchronous; it restores the register defaults and zeros both states.
// o_in_stall is high while a word is in flight; a finished word waits in the
// output register and blocks only the final store of the next word.
`include "multimode_state_variable_filter_top_assert.svh"

module multimode_state_variable_filter_top #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    input  logic                                  i_cfg_we,
    input  logic [msvf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [msvf_pkg::CFG_W-1:0]            i_cfg_data
);
    import msvf_pkg::*;

    localparam t_wide HALF    = t_wide'(1) <<< (COEF_FRAC_BITS - 1);
    localparam t_wide ONE     = t_wide'(1) <<< COEF_FRAC_BITS;
    localparam t_wide OUT_MAX = (t_wide'(1) <<< (SAMPLE_WIDTH - 1)) - t_wide'(1);
    localparam t_wide OUT_MIN = -OUT_MAX - t_wide'(1);

    typedef enum logic [4:0] {
        S_IDLE, S_DEN, S_DEN_W, S_NUM, S_NUM_W, S_DIV, S_DIV_W,
        S_LP, S_LP_W, S_HP, S_HP_W, S_MH, S_MH_W, S_MB, S_MB_W,
        S_ML, S_ML_W, S_OUT
    } t_state_e;

    t_state_e                   r_state;
    logic signed [GAIN_W-1:0]   r_hp_gain;
    logic signed [GAIN_W-1:0]   r_bp_gain;
    logic signed [GAIN_W-1:0]   r_lp_gain;
    logic [COEF_W-1:0]          r_damp;
    logic [COEF_W-1:0]          r_cut;
    t_state                     r_s1;
    t_state                     r_s2;
    t_state                     r_bp;
    t_state                     r_lp;
    t_state                     r_hp;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [DEN_W-1:0]           r_den;
    t_wide                      r_num;
    t_wide                      r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic                       r_out_valid;

    logic                       m_start;
    logic signed [MUL_A_W-1:0]  m_a;
    logic signed [MUL_B_W-1:0]  m_b;
    logic                       m_done;
    t_wide                      m_prod;
    logic                       d_start;
    logic                       d_done;
    t_wide                      d_quot;

    logic [COEF_W+1:0]          w_gt;
    t_wide                      w_prod_rs;
    t_wide                      w_acc_rs;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic                       w_load_out;

    function automatic t_wide rshift(t_wide v);
        return (v + HALF) >>> COEF_FRAC_BITS;
    endfunction

    // g + 2R, the inner factor of the denominator
    assign w_gt = {2'b0, r_cut} + {1'b0, r_damp, 1'b0};

    assign w_prod_rs  = rshift(m_prod);
    assign w_acc_rs   = rshift(r_acc);
    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (w_acc_rs > OUT_MAX) begin
            w_y = SAMPLE_WIDTH'(OUT_MAX);
        end else if (w_acc_rs < OUT_MIN) begin
            w_y = SAMPLE_WIDTH'(OUT_MIN);
        end else begin
            w_y = SAMPLE_WIDTH'(w_acc_rs);
        end
    end

    always_comb begin
        m_start = 1'b0;
        m_a     = '0;
        m_b     = '0;
        unique case (r_state)
            S_DEN: begin
                m_start = 1'b1;
                m_a     = $signed({{(MUL_A_W-COEF_W){1'b0}}, r_cut});
                m_b     = $signed({{(MUL_B_W-COEF_W-2){1'b0}}, w_gt});
            end
            S_NUM: begin
                m_start = 1'b1;
                m_a     = MUL_A_W'(r_x) - MUL_A_W'(r_s2);
                m_b     = $signed({{(MUL_B_W-COEF_W){1'b0}}, r_cut});
            end
            S_LP: begin
                m_start = 1'b1;
                m_a     = MUL_A_W'(r_bp);
                m_b     = $signed({{(MUL_B_W-COEF_W){1'b0}}, r_cut});
            end
            S_HP: begin
                m_start = 1'b1;
                m_a     = MUL_A_W'(r_bp);
                m_b     = $signed({{(MUL_B_W-COEF_W-1){1'b0}}, r_damp, 1'b0});
            end
            S_MH: begin
                m_start = 1'b1;
                m_a     = MUL_A_W'(r_hp);
                m_b     = MUL_B_W'(r_hp_gain);
            end
            S_MB: begin
                m_start = 1'b1;
                m_a     = MUL_A_W'(r_bp);
                m_b     = MUL_B_W'(r_bp_gain);
            end
            S_ML: begin
                m_start = 1'b1;
                m_a     = MUL_A_W'(r_lp);
                m_b     = MUL_B_W'(r_lp_gain);
            end
            default: ;
        endcase
    end

    assign d_start = (r_state == S_DIV);

    msvf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (m_done),
        .o_prod  (m_prod)
    );

    msvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hp_gain   <= '0;
            r_bp_gain   <= '0;
            r_lp_gain   <= LP_GAIN_RST;
            r_damp      <= DAMPING_RST;
            r_cut       <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // a changed coefficient restarts the integrators
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_HP_GAIN: begin
                        if ($signed(i_cfg_data) != r_hp_gain) begin
                            r_hp_gain <= $signed(i_cfg_data);
                            r_s1      <= '0;
                            r_s2      <= '0;
                        end
                    end
                    REG_BP_GAIN: begin
                        if ($signed(i_cfg_data) != r_bp_gain) begin
                            r_bp_gain <= $signed(i_cfg_data);
                            r_s1      <= '0;
                            r_s2      <= '0;
                        end
                    end
                    REG_LP_GAIN: begin
                        if ($signed(i_cfg_data) != r_lp_gain) begin
                            r_lp_gain <= $signed(i_cfg_data);
                            r_s1      <= '0;
                            r_s2      <= '0;
                        end
                    end
                    REG_DAMPING: begin
                        if (i_cfg_data[COEF_W-1:0] != r_damp) begin
                            r_damp <= i_cfg_data[COEF_W-1:0];
                            r_s1   <= '0;
                            r_s2   <= '0;
                        end
                    end
                    REG_CUTOFF: begin
                        if (i_cfg_data[COEF_W-1:0] != r_cut) begin
                            r_cut <= i_cfg_data[COEF_W-1:0];
                            r_s1  <= '0;
                            r_s2  <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample_in;
                        r_state <= S_DEN;
                    end
                end
                S_DEN:  r_state <= S_DEN_W;
                S_DEN_W: begin
                    if (m_done) begin
                        r_den   <= DEN_W'(ONE + w_prod_rs);
                        r_state <= S_NUM;
                    end
                end
                S_NUM:  r_state <= S_NUM_W;
                S_NUM_W: begin
                    if (m_done) begin
                        r_num   <= m_prod + (t_wide'(r_s1) <<< COEF_FRAC_BITS);
                        r_state <= S_DIV;
                    end
                end
                S_DIV:  r_state <= S_DIV_W;
                S_DIV_W: begin
                    if (d_done) begin
                        r_bp    <= sat_state(d_quot);
                        r_state <= S_LP;
                    end
                end
                S_LP:   r_state <= S_LP_W;
                S_LP_W: begin
                    if (m_done) begin
                        r_lp    <= sat_state(w_prod_rs + t_wide'(r_s2));
                        r_state <= S_HP;
                    end
                end
                S_HP:   r_state <= S_HP_W;
                S_HP_W: begin
                    if (m_done) begin
                        r_hp    <= sat_state(t_wide'(r_x) - t_wide'(r_lp) - w_prod_rs);
                        r_s1    <= sat_state((t_wide'(r_bp) <<< 1) - t_wide'(r_s1));
                        r_s2    <= sat_state((t_wide'(r_lp) <<< 1) - t_wide'(r_s2));
                        r_state <= S_MH;
                    end
                end
                S_MH:   r_state <= S_MH_W;
                S_MH_W: begin
                    if (m_done) begin
                        r_acc   <= m_prod;
                        r_state <= S_MB;
                    end
                end
                S_MB:   r_state <= S_MB_W;
                S_MB_W: begin
                    if (m_done) begin
                        r_acc   <= r_acc + m_prod;
                        r_state <= S_ML;
                    end
                end
                S_ML:   r_state <= S_ML_W;
                S_ML_W: begin
                    if (m_done) begin
                        r_acc   <= r_acc + m_prod;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_out       <= w_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    `MSVF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "accepted word did not start work")
    `MSVF_ASSERT_NOW(a_units_exclusive, 1'b1, !(m_done && d_done), "multiplier and divider finished together")
    `MSVF_ASSERT_NEXT(a_result_posted, w_load_out, o_out_valid && !o_in_stall, "result not posted after final step")

endmodule
